FILE: rtl/bpc_pkg.sv
// Package for the button press classifier: press codes, register map,
// per-button state record and reset constants. No dependencies.
package bpc_pkg;

    localparam int NUM_BUTTONS_DEF = 7;

    // APB register map: register i at byte address 4*i
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [15:0] LONG_PRESS_RST      = 16'd1000;
    localparam logic [15:0] KEEP_LONG_PRESS_RST = 16'd5000;
    localparam logic [15:0] REPEAT_INTERVAL_RST = 16'd500;
    localparam logic [9:0]  LOCK_POLLS_RST      = 10'd300;

    // beep period in 5 ms units, and beep counts
    localparam logic [7:0] BEEP_PERIOD_LONG  = 8'd200;
    localparam logic [7:0] BEEP_PERIOD_SHORT = 8'd20;
    localparam logic [1:0] BEEP_TIMES_KEEP   = 2'd3;
    localparam logic [1:0] BEEP_TIMES_ONE    = 2'd1;

    typedef enum logic [2:0] {
        CODE_NONE     = 3'd0,
        CODE_SHORT    = 3'd1,
        CODE_LONG     = 3'd2,
        CODE_INPRESS  = 3'd3,
        CODE_KEEPLONG = 3'd4
    } press_code_t;

    typedef enum logic [1:0] {
        REG_LONG_PRESS      = 2'd0,
        REG_KEEP_LONG_PRESS = 2'd1,
        REG_REPEAT_INTERVAL = 2'd2,
        REG_LOCK_POLLS      = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [15:0] long_press_ms;
        logic [15:0] keep_long_press_ms;
        logic [15:0] repeat_interval_ms;
        logic [9:0]  lock_polls;
    } cfg_t;

    typedef struct packed {
        logic        last_level;
        press_code_t press_state;
        logic [31:0] press_stamp;
        logic [31:0] repeat_stamp;
        logic [15:0] repeats;
        logic [9:0]  lock_count;
    } btn_state_t;

    typedef struct packed {
        logic       start;
        logic [7:0] period;
        logic [1:0] times;
    } beep_t;

    localparam btn_state_t BTN_STATE_RST = '{
        last_level:   1'b1,
        press_state:  CODE_NONE,
        press_stamp:  32'd0,
        repeat_stamp: 32'd0,
        repeats:      16'd0,
        lock_count:   10'd0
    };

endpackage

FILE: rtl/bpc_classify.sv
// Next-state and beep logic for one poll of one button.
// Purely combinational; uses bpc_pkg.
module bpc_classify
    import bpc_pkg::*;
(
    input  btn_state_t  cur,
    input  logic        level,
    input  logic [31:0] now_ms,
    input  cfg_t        cfg,
    output btn_state_t  nxt,
    output beep_t       beep
);

    logic [31:0] since_press;
    logic [31:0] since_repeat;
    logic        past_keep;
    logic        past_long;
    logic        past_repeat;

    // time differences wrap at 32 bits
    assign since_press  = now_ms - cur.press_stamp;
    assign since_repeat = now_ms - cur.repeat_stamp;
    assign past_keep    = since_press > {16'd0, cfg.keep_long_press_ms};
    assign past_long    = since_press > {16'd0, cfg.long_press_ms};
    assign past_repeat  = since_repeat > {16'd0, cfg.repeat_interval_ms};

    always_comb
    begin
        nxt  = cur;
        beep = '0;
        if (!level)
        begin
            if (cur.last_level)
            begin
                // press edge
                nxt.press_stamp  = now_ms;
                nxt.repeat_stamp = now_ms;
                nxt.repeats      = 16'd0;
            end
            else if (!past_keep && past_repeat)
            begin
                nxt.repeat_stamp = now_ms;
                nxt.press_state  = CODE_INPRESS;
                nxt.repeats      = cur.repeats + 16'd1;
            end
        end
        else if (!cur.last_level)
        begin
            // release edge: classify on held time
            beep.start     = 1'b1;
            nxt.lock_count = 10'd0;
            if (past_keep)
            begin
                nxt.press_state = CODE_KEEPLONG;
                beep.period     = BEEP_PERIOD_LONG;
                beep.times      = BEEP_TIMES_KEEP;
            end
            else if (past_long)
            begin
                nxt.press_state = CODE_LONG;
                beep.period     = BEEP_PERIOD_LONG;
                beep.times      = BEEP_TIMES_ONE;
            end
            else
            begin
                nxt.press_state = CODE_SHORT;
                beep.period     = BEEP_PERIOD_SHORT;
                beep.times      = BEEP_TIMES_ONE;
            end
        end
        nxt.last_level = level;

        // short and long codes time out after lock_polls polls
        if (nxt.press_state == CODE_LONG || nxt.press_state == CODE_SHORT)
        begin
            nxt.lock_count = nxt.lock_count + 10'd1;
            if (nxt.lock_count >= cfg.lock_polls)
            begin
                nxt.press_state = CODE_NONE;
                nxt.lock_count  = 10'd0;
            end
        end
    end

endmodule

FILE: rtl/button_press_classifier.sv
// Top level of the button press classifier: poll input register, per-button
// state table, result register and APB configuration registers.
// Uses bpc_pkg and bpc_classify.

// One poll transaction is taken every clock cycle when the result side keeps
// up. A poll is captured in an input register; its button's state record is
// then read, updated by bpc_classify and written back while the result is
// loaded into the output register, which waits while a held result has not
// been taken. Back-to-back polls of the same button are safe because the
// read-modify-write of the state table completes in the same cycle as the
// result load. Polls with an index at or above NUM_BUTTONS change nothing and
// return zero fields. Configuration registers are to be written over APB only
// while the block is idle; the block itself does not enforce this.
module button_press_classifier
    import bpc_pkg::*;
#(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              poll_valid,
    output logic              poll_ready,
    input  logic [2:0]        button_index,
    input  logic              pin_level,
    input  logic [31:0]       now_ms,

    output logic              result_valid,
    input  logic              result_ready,
    output logic [2:0]        result_index,
    output logic [2:0]        press_code,
    output logic [15:0]       repeat_count,
    output logic              beep_start,
    output logic [7:0]        beep_period,
    output logic [1:0]        beep_times,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int SEL_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

    // configuration
    logic [15:0] long_press_reg;
    logic [15:0] keep_long_press_reg;
    logic [15:0] repeat_interval_reg;
    logic [9:0]  lock_polls_reg;
    cfg_t        cfg;
    reg_index_t  reg_sel;
    logic        cfg_write;

    // pipeline
    logic        s1_valid_reg;
    logic [2:0]  s1_index_reg;
    logic        s1_level_reg;
    logic [31:0] s1_now_reg;
    logic        out_valid_reg;
    logic [2:0]  out_index_reg;
    logic [2:0]  out_code_reg;
    logic [15:0] out_repeats_reg;
    beep_t       out_beep_reg;

    logic        advance;
    logic        step;
    logic        poll_accept;
    logic [5:0]  idx_ext;
    logic        in_range;
    logic [SEL_W-1:0] sel;

    btn_state_t  state_reg [NUM_BUTTONS];
    btn_state_t  cur;
    btn_state_t  nxt;
    beep_t       beep;

    // ---------------- APB registers ----------------
    assign pready    = 1'b1;
    assign reg_sel   = reg_index_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_press_reg      <= LONG_PRESS_RST;
            keep_long_press_reg <= KEEP_LONG_PRESS_RST;
            repeat_interval_reg <= REPEAT_INTERVAL_RST;
            lock_polls_reg      <= LOCK_POLLS_RST;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                REG_LONG_PRESS:      long_press_reg      <= pwdata[15:0];
                REG_KEEP_LONG_PRESS: keep_long_press_reg <= pwdata[15:0];
                REG_REPEAT_INTERVAL: repeat_interval_reg <= pwdata[15:0];
                REG_LOCK_POLLS:      lock_polls_reg      <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_LONG_PRESS:      prdata = {16'd0, long_press_reg};
            REG_KEEP_LONG_PRESS: prdata = {16'd0, keep_long_press_reg};
            REG_REPEAT_INTERVAL: prdata = {16'd0, repeat_interval_reg};
            REG_LOCK_POLLS:      prdata = {22'd0, lock_polls_reg};
            default:             prdata = '0;
        endcase
    end

    assign cfg = '{
        long_press_ms:      long_press_reg,
        keep_long_press_ms: keep_long_press_reg,
        repeat_interval_ms: repeat_interval_reg,
        lock_polls:         lock_polls_reg
    };

    // ---------------- handshake ----------------
    assign advance     = !out_valid_reg || result_ready;
    assign poll_ready  = !s1_valid_reg || advance;
    assign poll_accept = poll_valid && poll_ready;
    assign step        = s1_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (poll_accept)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;
            if (advance)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (poll_accept)
        begin
            s1_index_reg <= button_index;
            s1_level_reg <= pin_level;
            s1_now_reg   <= now_ms;
        end
    end

    // ---------------- state table ----------------
    assign idx_ext  = {3'b000, s1_index_reg};
    assign in_range = idx_ext < 6'(NUM_BUTTONS);
    assign sel      = idx_ext[SEL_W-1:0];
    assign cur      = in_range ? state_reg[sel] : BTN_STATE_RST;

    bpc_classify u_classify (
        .cur    (cur),
        .level  (s1_level_reg),
        .now_ms (s1_now_reg),
        .cfg    (cfg),
        .nxt    (nxt),
        .beep   (beep)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BUTTONS; i++)
                state_reg[i] <= BTN_STATE_RST;
        end
        else if (step && in_range)
        begin
            state_reg[sel] <= nxt;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_index_reg <= s1_index_reg;
            if (in_range)
            begin
                out_code_reg    <= nxt.press_state;
                out_repeats_reg <= nxt.repeats;
                out_beep_reg    <= beep;
            end
            else
            begin
                out_code_reg    <= CODE_NONE;
                out_repeats_reg <= 16'd0;
                out_beep_reg    <= '0;
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign result_index = out_index_reg;
    assign press_code   = out_code_reg;
    assign repeat_count = out_repeats_reg;
    assign beep_start   = out_beep_reg.start;
    assign beep_period  = out_beep_reg.period;
    assign beep_times   = out_beep_reg.times;

    // ---------------- assertions ----------------
    a_no_beep_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !beep_start |-> beep_period == 8'd0 && beep_times == 2'd0)
        else $error("beep fields set without beep request");

    a_out_of_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && ({3'b000, result_index} >= 6'(NUM_BUTTONS))
        |-> press_code == CODE_NONE && repeat_count == 16'd0 && !beep_start)
        else $error("out-of-range poll produced a non-zero result");

    a_beep_not_inpress: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && beep_start |-> press_code != CODE_INPRESS)
        else $error("release reported as in-press");

    a_keep_long_beep: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && beep_start && press_code == CODE_KEEPLONG
        |-> beep_times == BEEP_TIMES_KEEP && beep_period == BEEP_PERIOD_LONG)
        else $error("keep-long beep pattern wrong");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> s1_valid_reg && $stable(s1_index_reg)
        && $stable(s1_now_reg) && $stable(s1_level_reg))
        else $error("stalled poll lost from input register");

endmodule

FILE: verif/tb_button_press_classifier.sv
// Self-checking testbench for button_press_classifier: poll transactions with
// an in-bench per-button press predictor, result scoreboard and APB set-up.
// Depends on rtl/bpc_pkg.sv and rtl/button_press_classifier.sv.
`timescale 1ns / 1ps

module tb_button_press_classifier
    import bpc_pkg::*;
();

    localparam int NUM_BTN = NUM_BUTTONS_DEF;
    localparam int STALL_PCT = 26;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic [2:0]  index;
        press_code_t code;
        logic [15:0] repeats;
        logic        beep;
        logic [7:0]  period;
        logic [1:0]  times;
    } press_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              poll_valid = 1'b0;
    logic              poll_ready;
    logic [2:0]        button_index = '0;
    logic              pin_level = 1'b1;
    logic [31:0]       now_ms = '0;
    logic              result_valid;
    logic              result_ready = 1'b0;
    logic [2:0]        result_index;
    logic [2:0]        press_code;
    logic [15:0]       repeat_count;
    logic              beep_start;
    logic [7:0]        beep_period;
    logic [1:0]        beep_times;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // predictor copy of configuration and per-button state
    logic [15:0] cfg_long;
    logic [15:0] cfg_keep_long;
    logic [15:0] cfg_repeat;
    logic [9:0]  cfg_lock_polls;
    logic        btn_level     [NUM_BTN];
    press_code_t btn_code      [NUM_BTN];
    logic [31:0] btn_press_at  [NUM_BTN];
    logic [31:0] btn_repeat_at [NUM_BTN];
    logic [15:0] btn_repeats   [NUM_BTN];
    logic [9:0]  btn_lock      [NUM_BTN];

    press_result_t pending_results[$];
    int            mismatches = 0;
    int            polls_sent = 0;
    bit            steady = 1'b0;
    logic [31:0]   t_now = '0;

    button_press_classifier uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .poll_valid   (poll_valid),
        .poll_ready   (poll_ready),
        .button_index (button_index),
        .pin_level    (pin_level),
        .now_ms       (now_ms),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_index (result_index),
        .press_code   (press_code),
        .repeat_count (repeat_count),
        .beep_start   (beep_start),
        .beep_period  (beep_period),
        .beep_times   (beep_times),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void flag_mismatch(input string what, input longint want,
                                          input longint got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %0d, got %0d", what, want, got);
    endfunction

    function automatic void reset_predictor();
        cfg_long       = LONG_PRESS_RST;
        cfg_keep_long  = KEEP_LONG_PRESS_RST;
        cfg_repeat     = REPEAT_INTERVAL_RST;
        cfg_lock_polls = LOCK_POLLS_RST;
        for (int b = 0; b < NUM_BTN; b++)
        begin
            btn_level[b]     = 1'b1;
            btn_code[b]      = CODE_NONE;
            btn_press_at[b]  = '0;
            btn_repeat_at[b] = '0;
            btn_repeats[b]   = '0;
            btn_lock[b]      = '0;
        end
    endfunction

    // Classifies one poll and advances that button's state.
    function automatic press_result_t classify_poll(input logic [2:0] idx,
                                                    input logic lvl,
                                                    input logic [31:0] t);
        press_result_t r;
        logic [31:0]   held;
        logic [31:0]   since_repeat;
        r = '0;
        r.index = idx;
        if (idx >= NUM_BTN)
            return r;
        held = t - btn_press_at[idx];
        since_repeat = t - btn_repeat_at[idx];
        if (!lvl)
        begin
            if (btn_level[idx])
            begin
                btn_press_at[idx]  = t;
                btn_repeat_at[idx] = t;
                btn_repeats[idx]   = '0;
            end
            else if (held > {16'd0, cfg_keep_long})
            begin
                // held past the keep-long limit: repeats stop
            end
            else if (since_repeat > {16'd0, cfg_repeat})
            begin
                btn_repeat_at[idx] = t;
                btn_code[idx]      = CODE_INPRESS;
                btn_repeats[idx]   = btn_repeats[idx] + 16'd1;
            end
        end
        else if (!btn_level[idx])
        begin
            r.beep = 1'b1;
            btn_lock[idx] = '0;
            if (held > {16'd0, cfg_keep_long})
            begin
                btn_code[idx] = CODE_KEEPLONG;
                r.period = BEEP_PERIOD_LONG;
                r.times  = BEEP_TIMES_KEEP;
            end
            else if (held > {16'd0, cfg_long})
            begin
                btn_code[idx] = CODE_LONG;
                r.period = BEEP_PERIOD_LONG;
                r.times  = BEEP_TIMES_ONE;
            end
            else
            begin
                btn_code[idx] = CODE_SHORT;
                r.period = BEEP_PERIOD_SHORT;
                r.times  = BEEP_TIMES_ONE;
            end
        end
        btn_level[idx] = lvl;
        if (btn_code[idx] == CODE_LONG || btn_code[idx] == CODE_SHORT)
        begin
            btn_lock[idx] = btn_lock[idx] + 10'd1;
            if (btn_lock[idx] >= cfg_lock_polls)
            begin
                btn_code[idx] = CODE_NONE;
                btn_lock[idx] = '0;
            end
        end
        r.code    = btn_code[idx];
        r.repeats = btn_repeats[idx];
        return r;
    endfunction

    // result side: random back-pressure and scoreboard
    always @(posedge clk)
    begin
        press_result_t want;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                if (pending_results.size() == 0)
                    flag_mismatch("unexpected result, index", -1, result_index);
                else
                begin
                    want = pending_results.pop_front();
                    if (result_index !== want.index)
                        flag_mismatch("result_index", want.index, result_index);
                    if (press_code !== want.code)
                        flag_mismatch("press_code", want.code, press_code);
                    if (repeat_count !== want.repeats)
                        flag_mismatch("repeat_count", want.repeats, repeat_count);
                    if (beep_start !== want.beep)
                        flag_mismatch("beep_start", want.beep, beep_start);
                    if (beep_period !== want.period)
                        flag_mismatch("beep_period", want.period, beep_period);
                    if (beep_times !== want.times)
                        flag_mismatch("beep_times", want.times, beep_times);
                end
            end
            result_ready <= steady || ($urandom_range(99) >= STALL_PCT);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((poll_valid && poll_ready) || (result_valid && result_ready) || psel)
                quiet = 0;
            else
                quiet++;
        end
        $display("== FAIL ==");
        $finish;
    end

    task automatic send_poll(input logic [2:0] idx, input logic lvl,
                             input logic [31:0] t);
        if (!steady && $urandom_range(99) < STALL_PCT)
        begin
            poll_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < STALL_PCT)
                @(posedge clk);
        end
        poll_valid   <= 1'b1;
        button_index <= idx;
        pin_level    <= lvl;
        now_ms       <= t;
        do
            @(posedge clk);
        while (!poll_ready);
        pending_results.push_back(classify_poll(idx, lvl, t));
        polls_sent++;
    endtask

    // Drains the block so that configuration can change.
    task automatic wait_idle();
        poll_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // APB write followed by a read-back of the same register.
    task automatic write_reg(input reg_index_t ri, input logic [31:0] value);
        logic [31:0] stored;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {ri, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (ri)
            REG_LONG_PRESS:      cfg_long       = value[15:0];
            REG_KEEP_LONG_PRESS: cfg_keep_long  = value[15:0];
            REG_REPEAT_INTERVAL: cfg_repeat     = value[15:0];
            REG_LOCK_POLLS:      cfg_lock_polls = value[9:0];
            default: ;
        endcase
        stored = (ri == REG_LOCK_POLLS) ? {22'd0, value[9:0]} : {16'd0, value[15:0]};
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== stored)
            flag_mismatch("register read-back", stored, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_settings(input logic [15:0] long_ms, input logic [15:0] keep_ms,
                                  input logic [15:0] rep_ms, input logic [9:0] lock);
        wait_idle();
        write_reg(REG_LONG_PRESS, {16'd0, long_ms});
        write_reg(REG_KEEP_LONG_PRESS, {16'd0, keep_ms});
        write_reg(REG_REPEAT_INTERVAL, {16'd0, rep_ms});
        write_reg(REG_LOCK_POLLS, {22'd0, lock});
    endtask

    task automatic send_noise();
        logic [31:0] t;
        t = ($urandom_range(3) == 0) ? $urandom() : t_now;
        send_poll(3'($urandom_range(7)), 1'($urandom_range(1)), t);
    endtask

    // Press, a few held polls, release, then some released polls so that
    // pending short and long codes count down.
    task automatic run_press_sequence();
        int          b;
        int          hold;
        int          n;
        logic [31:0] t0;
        b = $urandom_range(NUM_BTN - 1);
        case ($urandom_range(5))
            0: hold = $urandom_range(0, cfg_long);
            1: hold = $urandom_range(cfg_long, cfg_keep_long);
            2: hold = cfg_keep_long + $urandom_range(1, 3000);
            3: hold = cfg_long;
            4: hold = cfg_long + 1;
            default: hold = cfg_keep_long + $urandom_range(0, 1);
        endcase
        if ($urandom_range(7) == 0)
            t_now = $urandom();
        t0 = t_now;
        send_poll(3'(b), 1'b0, t0);
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(4) == 0)
                send_noise();
            send_poll(3'(b), 1'b0, t0 + 32'((hold * (i + 1)) / (n + 1)));
        end
        send_poll(3'(b), 1'b1, t0 + 32'(hold));
        t_now = t0 + 32'(hold) + 32'($urandom_range(1, 20));
        n = $urandom_range(0, 8);
        for (int i = 0; i < n; i++)
        begin
            t_now = t_now + 32'($urandom_range(0, 30));
            send_poll(3'(b), 1'b1, t_now);
        end
    endtask

    task automatic run_random_phase(input int count);
        int target;
        target = polls_sent + count;
        while (polls_sent < target)
        begin
            if ($urandom_range(99) < 75)
                run_press_sequence();
            else
                send_noise();
        end
    endtask

    // Reset configuration: repeats, every classification, wrap and edge cases.
    task automatic test_directed_defaults();
        send_poll(3'd0, 1'b1, 32'd0);
        send_poll(3'd0, 1'b0, 32'd100);
        send_poll(3'd0, 1'b0, 32'd600);            // interval reached, not passed
        send_poll(3'd0, 1'b0, 32'd601);            // first in-press repeat
        send_poll(3'd0, 1'b1, 32'd1100);           // held exactly the long limit
        send_poll(3'd1, 1'b0, 32'd2000);
        send_poll(3'd1, 1'b1, 32'd3001);           // just over: long
        send_poll(3'd2, 1'b0, 32'd4000);
        send_poll(3'd2, 1'b0, 32'd9000);           // held exactly keep-long
        send_poll(3'd2, 1'b0, 32'd9001);           // past keep-long: no repeat
        send_poll(3'd2, 1'b1, 32'd9001);
        send_poll(3'd3, 1'b0, 32'hFFFF_FF00);
        send_poll(3'd3, 1'b1, 32'h0000_0100);      // held time wraps
        send_poll(3'd7, 1'b0, 32'hFFFF_FFFF);      // index out of range
        send_poll(3'd7, 1'b1, 32'd0);
        send_poll(3'd0, 1'b0, 32'd1200);           // press edge with short pending
        send_poll(3'd0, 1'b1, 32'd1200);
        send_poll(3'd6, 1'b0, 32'hAAAA_5555);
        send_poll(3'd6, 1'b1, 32'h5555_AAAA);
        send_poll(3'd5, 1'b0, 32'h8000_0000);
        send_poll(3'd5, 1'b0, 32'h8000_01F5);
        send_poll(3'd5, 1'b1, 32'h8000_1388);      // held exactly keep-long: long
        send_poll(3'd4, 1'b1, 32'd0);
    endtask

    // Short codes under the smallest lock settings, zero included.
    task automatic test_lock_limits();
        for (int lock = 0; lock <= 2; lock++)
        begin
            wait_idle();
            write_reg(REG_LOCK_POLLS, 32'(lock));
            send_poll(3'd4, 1'b0, 32'd100);
            send_poll(3'd4, 1'b1, 32'd200);
            send_poll(3'd4, 1'b1, 32'd210);
        end
    endtask

    // Full throughput, no stalls on either side.
    task automatic test_steady_stream();
        apply_settings(16'd1000, 16'd5000, 16'd500, 10'd5);
        steady = 1'b1;
        run_random_phase(250);
        steady = 1'b0;
    endtask

    task automatic test_low_extremes();
        apply_settings(16'd0, 16'd0, 16'd0, 10'd1);
        run_random_phase(150);
    endtask

    task automatic test_high_extremes();
        apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 10'd1023);
        run_random_phase(150);
    endtask

    task automatic test_random_settings();
        repeat (2)
        begin
            apply_settings(16'($urandom_range(0, 4000)), 16'($urandom_range(0, 8000)),
                           16'($urandom_range(0, 1000)), 10'($urandom_range(1, 40)));
            run_random_phase(150);
        end
    endtask

    initial
    begin
        reset_predictor();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_defaults();
        test_lock_limits();
        test_steady_stream();
        test_low_extremes();
        test_high_extremes();
        test_random_settings();

        wait_idle();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
